[design/a64_fixup_patcher_core_defines.svh]
// Assertion macros for the fixup patcher; clk and rst_n must be in scope.
`ifndef A64_FIXUP_PATCHER_CORE_DEFINES_SVH
`define A64_FIXUP_PATCHER_CORE_DEFINES_SVH

`define A64FXP_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("a64fxp check failed");

`define A64FXP_CHECK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (expr)) \
    else $error("a64fxp check failed");

`endif

[design/a64fxp_pkg.sv]
`default_nettype none
package a64fxp_pkg;

  localparam logic [2:0] OP_B26       = 3'd0;
  localparam logic [2:0] OP_CBZ19     = 3'd1;
  localparam logic [2:0] OP_IAT_PAGE  = 3'd2;
  localparam logic [2:0] OP_IAT_LO12  = 3'd3;
  localparam logic [2:0] OP_DATA_PAGE = 3'd4;
  localparam logic [2:0] OP_DATA_LO12 = 3'd5;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNBOUND      = 3'd1;
  localparam logic [2:0] ST_MISALIGN     = 3'd2;
  localparam logic [2:0] ST_BRANCH_RANGE = 3'd3;
  localparam logic [2:0] ST_CBZ_RANGE    = 3'd4;
  localparam logic [2:0] ST_ADRP_RANGE   = 3'd5;

  localparam logic [1:0] REG_TEXT_RVA  = 2'd0;
  localparam logic [1:0] REG_IAT_BASE  = 2'd1;
  localparam logic [1:0] REG_DATA_BASE = 2'd2;

  localparam logic [31:0] B26_OPCODE    = 32'h1400_0000;
  localparam logic [31:0] CBZ_KEEP_MASK = 32'hFF00_001F;
  localparam logic [31:0] ADRP_KEEP_MASK = 32'h9F00_001F;
  localparam logic [31:0] LO12_KEEP_MASK = ~(32'h0000_0FFF << 10);

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] existing_word;
    logic [31:0] instr_offset;
    logic [31:0] target;
    logic        label_bound;
  } in_req_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic [2:0]  status;
  } out_res_t;

  typedef struct packed {
    logic [31:0] text_rva;
    logic [31:0] iat_base_rva;
    logic [31:0] data_base_rva;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] word;
    logic        label_bound;
    logic [31:0] pc_addr;
    logic [31:0] tgt_addr;
    logic [32:0] br_delta;
  } addr_stage_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] word;
    logic [2:0]  status;
    logic [25:0] imm;
  } check_stage_t;

endpackage
`default_nettype wire

[design/a64fxp_addr_stage.sv]
`default_nettype none
module a64fxp_addr_stage
  import a64fxp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire in_req_t     in_req,
  input  wire cfg_regs_t   cfg,
  output logic             s1_valid,
  output addr_stage_t      s1_data
);

  logic        valid_r;
  addr_stage_t data_r;
  addr_stage_t data_nxt;
  logic [31:0] base;

  always_comb begin
    case (in_req.op) inside
      OP_IAT_PAGE, OP_IAT_LO12: base = cfg.iat_base_rva;
      default:                  base = cfg.data_base_rva;
    endcase
    data_nxt.op          = in_req.op;
    data_nxt.word        = in_req.existing_word;
    data_nxt.label_bound = in_req.label_bound;
    data_nxt.pc_addr     = cfg.text_rva + in_req.instr_offset;
    data_nxt.tgt_addr    = base + in_req.target;
    data_nxt.br_delta    = {1'b0, in_req.target} - {1'b0, in_req.instr_offset};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    data_r <= data_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule
`default_nettype wire

[design/a64fxp_check_stage.sv]
`default_nettype none
module a64fxp_check_stage
  import a64fxp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s1_valid,
  input  wire addr_stage_t s1_data,
  output logic             s2_valid,
  output check_stage_t     s2_data
);

  logic         valid_r;
  check_stage_t data_r;
  check_stage_t data_nxt;
  logic [21:0]  pages;
  logic         b26_oor;
  logic         cbz_oor;
  logic         adrp_oor;
  logic         misaligned;

  always_comb begin
    pages      = {2'b00, s1_data.tgt_addr[31:12]} - {2'b00, s1_data.pc_addr[31:12]};
    adrp_oor   = pages[21] != pages[20];
    misaligned = s1_data.br_delta[1:0] != 2'b00;
    b26_oor    = s1_data.br_delta[32:27] != {6{s1_data.br_delta[32]}};
    cbz_oor    = s1_data.br_delta[32:20] != {13{s1_data.br_delta[32]}};

    data_nxt.op     = s1_data.op;
    data_nxt.word   = s1_data.word;
    data_nxt.status = ST_OK;
    data_nxt.imm    = '0;
    case (s1_data.op) inside
      OP_B26, OP_CBZ19: begin
        if (!s1_data.label_bound) begin
          data_nxt.status = ST_UNBOUND;
        end else if (misaligned) begin
          data_nxt.status = ST_MISALIGN;
        end else if (s1_data.op == OP_B26 && b26_oor) begin
          data_nxt.status = ST_BRANCH_RANGE;
        end else if (s1_data.op == OP_CBZ19 && cbz_oor) begin
          data_nxt.status = ST_CBZ_RANGE;
        end
        data_nxt.imm = s1_data.br_delta[27:2];
      end
      OP_IAT_PAGE, OP_DATA_PAGE: begin
        if (adrp_oor) begin
          data_nxt.status = ST_ADRP_RANGE;
        end
        data_nxt.imm = {5'b0, pages[20:0]};
      end
      OP_IAT_LO12, OP_DATA_LO12: begin
        data_nxt.imm = {14'b0, s1_data.tgt_addr[11:0]};
      end
      default: begin
        data_nxt.imm = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s1_valid;
    end
    data_r <= data_nxt;
  end

  assign s2_valid = valid_r;
  assign s2_data  = data_r;

endmodule
`default_nettype wire

[design/a64fxp_patch_stage.sv]
`default_nettype none
module a64fxp_patch_stage
  import a64fxp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s2_valid,
  input  wire check_stage_t s2_data,
  output logic              out_strobe,
  output out_res_t          out_res
);

  logic     valid_r;
  out_res_t res_r;
  out_res_t res_nxt;

  always_comb begin
    res_nxt.status       = s2_data.status;
    res_nxt.patched_word = s2_data.word;
    if (s2_data.status == ST_OK) begin
      case (s2_data.op) inside
        OP_B26: begin
          res_nxt.patched_word = B26_OPCODE | {6'b0, s2_data.imm};
        end
        OP_CBZ19: begin
          res_nxt.patched_word = (s2_data.word & CBZ_KEEP_MASK)
                               | {8'b0, s2_data.imm[18:0], 5'b0};
        end
        OP_IAT_PAGE, OP_DATA_PAGE: begin
          res_nxt.patched_word = (s2_data.word & ADRP_KEEP_MASK)
                               | {1'b0, s2_data.imm[1:0], 29'b0}
                               | {8'b0, s2_data.imm[20:2], 5'b0};
        end
        OP_IAT_LO12, OP_DATA_LO12: begin
          res_nxt.patched_word = (s2_data.word & LO12_KEEP_MASK)
                               | {10'b0, s2_data.imm[11:0], 10'b0};
        end
        default: begin
          res_nxt.patched_word = s2_data.word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_valid;
    end
    res_r <= res_nxt;
  end

  assign out_strobe = valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

[design/a64_fixup_patcher_core.sv]
// An accepted request has its result strobe raised once it has passed the address, check and patch registers.
// Throughput: one request per cycle; three register stages (address add, check, patch).
// The receiver cannot stall; busy is high only while rst_n is low.
// Reset: synchronous active-low rst_n clears the stage valid bits and the three
// base registers to zero.
`default_nettype none
`include "a64_fixup_patcher_core_defines.svh"
module a64_fixup_patcher_core
  import a64fxp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  output logic             out_strobe,
  output out_res_t         out_res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  cfg_regs_t    cfg_r;
  logic         in_accept;
  logic         s1_valid;
  addr_stage_t  s1_data;
  logic         s2_valid;
  check_stage_t s2_data;

  assign busy      = !rst_n;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_RVA:  cfg_r.text_rva      <= cfg_wdata;
        REG_IAT_BASE:  cfg_r.iat_base_rva  <= cfg_wdata;
        REG_DATA_BASE: cfg_r.data_base_rva <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  a64fxp_addr_stage u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_req   (in_req),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  a64fxp_check_stage u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  a64fxp_patch_stage u_patch (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2_data    (s2_data),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  `A64FXP_CHECK_ALWAYS(a_strobe_latency, out_strobe == $past(in_accept, 3))
  `A64FXP_CHECK_IMP(a_error_passthru, out_strobe && out_res.status != ST_OK,
                    out_res.patched_word == $past(in_req.existing_word, 3))
  `A64FXP_CHECK_IMP(a_unbound_branch_only, out_strobe && out_res.status == ST_UNBOUND,
                    $past(in_req.op, 3) == OP_B26 || $past(in_req.op, 3) == OP_CBZ19)

endmodule
`default_nettype wire

[tb/sv/tb.sv]
module tb;
  import a64fxp_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_strobe;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TEXT_RVA;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] text_rva_m = '0;
  logic [31:0] iat_base_m = '0;
  logic [31:0] data_base_m = '0;

  out_res_t patched_q[$];
  int send_idle_pct = 0;
  int stall_cycles = 0;
  bit failed = 1'b0;

  a64_fixup_patcher_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_strobe(out_strobe),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic out_res_t patch_fixup(in_req_t r);
    out_res_t res;
    longint delta;
    longint imm;
    longint lim;
    longint pages;
    logic [31:0] addr;
    logic [31:0] pc_page;
    logic [31:0] tg_page;
    res.patched_word = r.existing_word;
    res.status = ST_OK;
    case (r.op) inside
      OP_B26, OP_CBZ19: begin
        lim = (r.op == OP_B26) ? (longint'(1) << 25) : (longint'(1) << 18);
        delta = longint'({32'b0, r.target}) - longint'({32'b0, r.instr_offset});
        imm = delta >>> 2;
        if (!r.label_bound) begin
          res.status = ST_UNBOUND;
        end else if (delta[1:0] != 2'b00) begin
          res.status = ST_MISALIGN;
        end else if (imm < -lim || imm >= lim) begin
          res.status = (r.op == OP_B26) ? ST_BRANCH_RANGE : ST_CBZ_RANGE;
        end else if (r.op == OP_B26) begin
          res.patched_word = B26_OPCODE | {6'b0, imm[25:0]};
        end else begin
          res.patched_word = (r.existing_word & CBZ_KEEP_MASK) | {8'b0, imm[18:0], 5'b0};
        end
      end
      OP_IAT_PAGE, OP_DATA_PAGE: begin
        addr = ((r.op == OP_IAT_PAGE) ? iat_base_m : data_base_m) + r.target;
        pc_page = (text_rva_m + r.instr_offset) & ~32'hFFF;
        tg_page = addr & ~32'hFFF;
        pages = (longint'({32'b0, tg_page}) - longint'({32'b0, pc_page})) >>> 12;
        if (pages < -(longint'(1) << 20) || pages >= (longint'(1) << 20)) begin
          res.status = ST_ADRP_RANGE;
        end else begin
          res.patched_word = (r.existing_word & ADRP_KEEP_MASK)
                           | {1'b0, pages[1:0], 5'b0, pages[20:2], 5'b0};
        end
      end
      OP_IAT_LO12, OP_DATA_LO12: begin
        addr = ((r.op == OP_IAT_LO12) ? iat_base_m : data_base_m) + r.target;
        res.patched_word = (r.existing_word & LO12_KEEP_MASK) | {10'b0, addr[11:0], 10'b0};
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic in_req_t make_fixup(logic [2:0] op, logic [31:0] word, logic [31:0] off,
                                         logic [31:0] tgt, logic bound);
    in_req_t r;
    r.op = op;
    r.existing_word = word;
    r.instr_offset = off;
    r.target = tgt;
    r.label_bound = bound;
    return r;
  endfunction

  function automatic in_req_t random_fixup();
    in_req_t r;
    int unsigned pick;
    longint reach;
    longint words;
    longint d;
    pick = $urandom_range(99);
    r.existing_word = $urandom();
    r.instr_offset = $urandom();
    r.target = $urandom();
    r.label_bound = ($urandom_range(9) != 0);
    if (pick < 30) r.op = OP_B26;
    else if (pick < 55) r.op = OP_CBZ19;
    else if (pick < 65) r.op = OP_IAT_PAGE;
    else if (pick < 75) r.op = OP_IAT_LO12;
    else if (pick < 85) r.op = OP_DATA_PAGE;
    else if (pick < 95) r.op = OP_DATA_LO12;
    else r.op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
    if (r.op == OP_B26 || r.op == OP_CBZ19) begin
      reach = (r.op == OP_B26) ? (longint'(1) << 27) : (longint'(1) << 20);
      words = reach >>> 2;
      case ($urandom_range(9)) inside
        [0:4]: d = (longint'($urandom_range(32'(2 * words - 1))) - words) * 4;
        [5:6]: begin
          case ($urandom_range(3))
            0: d = reach - 4;
            1: d = -reach;
            2: d = reach;
            default: d = -reach - 4;
          endcase
        end
        7: d = longint'({32'b0, r.target}) - longint'({32'b0, r.instr_offset});
        8: d = (longint'($urandom_range(255)) - 128) * 4 + longint'($urandom_range(1, 3));
        default: d = (longint'($urandom_range(63)) - 32) * 4;
      endcase
      r.target = r.instr_offset + d[31:0];
    end
    return r;
  endfunction

  task automatic send_fixup(input in_req_t req);
    start <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    patched_q = {patched_q, patch_fixup(req)};
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      in_req <= random_fixup();
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (patched_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_bases(input logic [31:0] text_v, input logic [31:0] iat_v,
                               input logic [31:0] data_v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_TEXT_RVA;
    cfg_wdata <= text_v;
    @(posedge clk);
    cfg_index <= REG_IAT_BASE;
    cfg_wdata <= iat_v;
    @(posedge clk);
    cfg_index <= REG_DATA_BASE;
    cfg_wdata <= data_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_rva_m = text_v;
    iat_base_m = iat_v;
    data_base_m = data_v;
  endtask

  task automatic test_branch26();
    send_fixup(make_fixup(OP_B26, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0008, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h0000_0000, 32'h0001_0000, 32'h0000_FFC0, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'h0001_0000, 32'h0801_FFFC, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'h0801_0000, 32'h0001_0000, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'h0001_0000, 32'h0801_0000, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'h0001_0000, 32'h0001_0002, 1'b0));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'h0001_0000, 32'h0801_0002, 1'b1));
    send_fixup(make_fixup(OP_B26, 32'h1234_5678, 32'hFFFF_FFF0, 32'h0000_0010, 1'b1));
  endtask

  task automatic test_cbz19();
    send_fixup(make_fixup(OP_CBZ19, 32'hFFFF_FFFF, 32'h0040_0000, 32'h0040_0010, 1'b1));
    send_fixup(make_fixup(OP_CBZ19, 32'h0000_0000, 32'h0040_0000, 32'h004F_FFFC, 1'b1));
    send_fixup(make_fixup(OP_CBZ19, 32'hB400_0001, 32'h0040_0000, 32'h0030_0000, 1'b1));
    send_fixup(make_fixup(OP_CBZ19, 32'hB400_0001, 32'h0040_0000, 32'h0050_0000, 1'b1));
    send_fixup(make_fixup(OP_CBZ19, 32'hB400_0001, 32'h0040_0000, 32'h0040_0010, 1'b0));
    send_fixup(make_fixup(OP_CBZ19, 32'hB400_0001, 32'h0040_0000, 32'h0040_0001, 1'b1));
  endtask

  task automatic test_page_fixups();
    send_fixup(make_fixup(OP_IAT_PAGE, 32'hFFFF_FFFF, 32'h0001_2345, 32'hFFFF_FFFF, 1'b0));
    send_fixup(make_fixup(OP_DATA_PAGE, 32'h9000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    program_bases(32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_0001);
    send_fixup(make_fixup(OP_IAT_PAGE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_F000, 1'b1));
    send_fixup(make_fixup(OP_DATA_PAGE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0));
  endtask

  task automatic test_low12_fixups();
    send_fixup(make_fixup(OP_IAT_LO12, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_1ABC, 1'b1));
    send_fixup(make_fixup(OP_DATA_LO12, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
  endtask

  task automatic test_unknown_kinds();
    send_fixup(make_fixup(OP_RSVD6, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0002, 1'b1));
    send_fixup(make_fixup(OP_RSVD7, 32'h2152_4110, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
  endtask

  task automatic test_random_traffic(input int idle_pct);
    send_idle_pct = idle_pct;
    program_bases($urandom(), $urandom(), $urandom());
    repeat (240) send_fixup(random_fixup());
    program_bases($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
                  $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
                  $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
    repeat (220) send_fixup(random_fixup());
  endtask

  always @(posedge clk) begin : check_results
    out_res_t want;
    if (rst_n && out_strobe) begin
      if (patched_q.size() == 0) begin
        $error("result with no request pending: patched_word %h status %0d",
               out_res.patched_word, out_res.status);
        failed = 1'b1;
      end else begin
        want = patched_q.pop_front();
        if (out_res.patched_word !== want.patched_word) begin
          $error("patched_word: expected %h, got %h", want.patched_word, out_res.patched_word);
          failed = 1'b1;
        end
        if (out_res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_res.status);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    test_branch26();
    test_cbz19();
    test_page_fixups();
    test_low12_fixups();
    test_unknown_kinds();
    test_random_traffic(25);
    test_random_traffic(59);
    test_random_traffic(0);
    drain_results();
    repeat (8) @(posedge clk);
    if (failed || patched_q.size() != 0) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

endmodule

[a64_fixup_patcher_core.f]
+incdir+design
design/a64fxp_pkg.sv
design/a64fxp_addr_stage.sv
design/a64fxp_check_stage.sv
design/a64fxp_patch_stage.sv
design/a64_fixup_patcher_core.sv
tb/sv/tb.sv
